// ===== src/hmc_pkg.sv =====
`timescale 1ns / 1ps

package hmc_pkg;

	// Operation codes of the input word.
	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_FILL   = 2'd1;
	localparam logic [1:0] OP_FRAME  = 2'd2;

	// Hash multipliers and fold distance.
	localparam logic [31:0] MUL_MODEL  = 32'h9E37_79B1;
	localparam logic [31:0] MUL_X      = 32'h85EB_CA6B;
	localparam logic [31:0] MUL_Y      = 32'hC2B2_AE35;
	localparam logic [31:0] MUL_Z      = 32'h27D4_EB2F;
	localparam int unsigned FOLD_SHIFT = 16;

	// Generation zero marks an empty slot, so counting starts at one.
	localparam logic [31:0] GEN_START = 32'd1;
	localparam logic [31:0] GEN_LAST  = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] model_id;
		logic [31:0] point_x;
		logic [31:0] point_y;
		logic [31:0] point_z;
		logic [31:0] fill_leaf;
	} query_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] leaf_out;
	} answer_t;

	typedef struct packed {
		logic [31:0] generation;
		logic [31:0] model;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] leaf;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic in_open;
		logic read;
		logic finish;
		logic clear_wr;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_taken;
		logic out_free;
		logic wrap;
		logic clear_last;
	} sts_t;

endpackage

// ===== src/hmc_stream_if.sv =====
`timescale 1ns / 1ps

interface hmc_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== src/hmc_ctrl.sv =====
`timescale 1ns / 1ps

module hmc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  hmc_pkg::sts_t   sts,
	output hmc_pkg::cmd_t   cmd
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_FINISH
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (sts.clear_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (sts.in_taken) state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (sts.out_free) state_q <= sts.wrap ? ST_CLEAR : ST_IDLE;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// The finish step waits until the result register can take a new word.
	always_comb begin
		cmd          = '0;
		cmd.in_open  = (state_q == ST_IDLE);
		cmd.read     = (state_q == ST_READ);
		cmd.finish   = (state_q == ST_FINISH) && sts.out_free;
		cmd.clear_wr = (state_q == ST_CLEAR);
	end

endmodule

// ===== src/hmc_datapath.sv =====
`timescale 1ns / 1ps

module hmc_datapath #(
	parameter int CACHE_ENTRIES = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  hmc_pkg::cmd_t cmd,
	output hmc_pkg::sts_t sts,
	hmc_stream_if.sink    query,
	hmc_stream_if.source  answer,
	hmc_stream_if.sink    cfg
);

	localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(CACHE_ENTRIES - 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CACHE_ENTRIES - 1);

	hmc_pkg::entry_t mem [CACHE_ENTRIES];

	hmc_pkg::query_t  key_q;
	logic [31:0]      prod_model_s1;
	logic [31:0]      prod_x_s1;
	logic [31:0]      prod_y_s1;
	logic [31:0]      prod_z_s1;
	logic [IDX_W-1:0] idx_s2;
	hmc_pkg::entry_t  rd_s2;
	hmc_pkg::answer_t out_q;
	logic             out_full_q;
	logic             en_q;
	logic [31:0]      gen_q;
	logic [IDX_W-1:0] clr_q;

	logic [31:0]      hash;
	logic [31:0]      fold;
	logic [IDX_W-1:0] idx;
	logic             load;
	logic             is_lookup;
	logic             is_fill;
	logic             is_frame;
	logic             match;
	hmc_pkg::entry_t  new_entry;

	assign load        = query.valid && query.ready;
	assign query.ready = cmd.in_open;
	assign cfg.ready   = 1'b1;

	assign is_lookup = (key_q.operation == hmc_pkg::OP_LOOKUP);
	assign is_fill   = (key_q.operation == hmc_pkg::OP_FILL);
	assign is_frame  = (key_q.operation == hmc_pkg::OP_FRAME);

	assign hash = prod_model_s1 ^ prod_x_s1 ^ prod_y_s1 ^ prod_z_s1;
	assign fold = hash ^ (hash >> hmc_pkg::FOLD_SHIFT);
	assign idx  = fold[IDX_W-1:0] & IDX_MASK;

	// Slots with generation zero never match, since the frame count is never zero.
	assign match = en_q && is_lookup && (rd_s2.generation == gen_q)
		&& (rd_s2.model == key_q.model_id) && (rd_s2.x == key_q.point_x)
		&& (rd_s2.y == key_q.point_y) && (rd_s2.z == key_q.point_z);

	always_comb begin
		new_entry            = '0;
		new_entry.generation = gen_q;
		new_entry.model      = key_q.model_id;
		new_entry.x          = key_q.point_x;
		new_entry.y          = key_q.point_y;
		new_entry.z          = key_q.point_z;
		new_entry.leaf       = key_q.fill_leaf;
	end

	always_comb begin
		sts            = '0;
		sts.in_taken   = load;
		sts.out_free   = !out_full_q || answer.ready;
		sts.wrap       = is_frame && (gen_q == hmc_pkg::GEN_LAST);
		sts.clear_last = (clr_q == IDX_LAST);
	end

	// Key capture and hash products.
	always_ff @(posedge clk) begin
		if (load) begin
			key_q         <= query.payload;
			prod_model_s1 <= query.payload.model_id * hmc_pkg::MUL_MODEL;
			prod_x_s1     <= query.payload.point_x * hmc_pkg::MUL_X;
			prod_y_s1     <= query.payload.point_y * hmc_pkg::MUL_Y;
			prod_z_s1     <= query.payload.point_z * hmc_pkg::MUL_Z;
		end
	end

	// Table read and write.
	always_ff @(posedge clk) begin
		if (cmd.read) begin
			idx_s2 <= idx;
			rd_s2  <= mem[idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_wr) begin
			mem[clr_q] <= '0;
		end else if (cmd.finish && is_fill && en_q) begin
			mem[idx_s2] <= new_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.hit      <= match;
			out_q.leaf_out <= match ? rd_s2.leaf : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
			en_q       <= 1'b1;
			gen_q      <= hmc_pkg::GEN_START;
			clr_q      <= '0;
		end else begin
			if (cmd.finish) begin
				out_full_q <= 1'b1;
			end else if (answer.ready) begin
				out_full_q <= 1'b0;
			end
			if (cfg.valid) begin
				en_q <= cfg.payload;
			end
			if (cmd.finish && is_frame) begin
				gen_q <= sts.wrap ? hmc_pkg::GEN_START : gen_q + 32'd1;
			end
			if (cmd.finish && sts.wrap) begin
				clr_q <= '0;
			end else if (cmd.clear_wr) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	assign answer.valid   = out_full_q;
	assign answer.payload = out_q;

endmodule

// ===== src/hashed_memo_cache_with_generation.sv =====
`timescale 1ns / 1ps
// Each query word passes through accept, table read, and compare and update; the next
// query word is accepted only once the finish step has run, and that step waits while
// the result register still holds a word that the answer channel has not taken.
// After reset, and after a new-frame word that wraps the generation count, a clearing
// pass over all CACHE_ENTRIES slots zeroes the stored generations; no query is taken meanwhile.

module hashed_memo_cache_with_generation #(
	parameter int CACHE_ENTRIES = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	hmc_stream_if.sink   query,
	hmc_stream_if.source answer,
	hmc_stream_if.sink   cfg
);

	// The controller sequences each word through capture, read and finish, and
	// runs the clearing pass; the datapath holds the table, the hash, the frame
	// generation, the enable register and the result register.
	hmc_pkg::cmd_t cmd;
	hmc_pkg::sts_t sts;

	hmc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	hmc_datapath #(
		.CACHE_ENTRIES (CACHE_ENTRIES)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.query  (query),
		.answer (answer),
		.cfg    (cfg)
	);

	// Only one word is in flight, so an accept is never followed directly by another.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(query.valid && query.ready) |=> !query.ready)
		else $error("query accepted while a word was in flight");

	// A finish step always leaves a result word on the answer channel.
	a_finish_offers: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> answer.valid)
		else $error("finish step did not produce a result word");

	// The table is never open to queries while it is being cleared.
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_wr |-> !query.ready)
		else $error("query channel open during clearing pass");

	// A miss always reports a zero leaf.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(answer.valid && !answer.payload.hit) |-> (answer.payload.leaf_out == 32'd0))
		else $error("miss with a non-zero leaf");

endmodule
